// ===== rtl/core/smd_pkg.sv =====
// ----------------------------------------------------------------------------
// smd_pkg
// Shared types and constants of the Sobel magnitude and direction block.
// ----------------------------------------------------------------------------
`default_nettype none

package smd_pkg;

  localparam int MAX_WIDTH   = 1024;
  localparam int MAX_HEIGHT  = 1024;
  localparam int CNT_W       = 11;
  localparam int PIX_W       = 8;
  localparam int LB_AW       = $clog2(MAX_WIDTH);
  localparam int OFIFO_DEPTH = 8;
  localparam int OFIFO_AW    = $clog2(OFIFO_DEPTH);

  typedef logic [PIX_W-1:0] pix_t;
  typedef logic [CNT_W-1:0] cnt_t;

  localparam cnt_t RESET_DIM  = cnt_t'(512);
  localparam cnt_t WIDTH_MIN  = cnt_t'(3);
  localparam cnt_t WIDTH_MAX  = cnt_t'(MAX_WIDTH);
  localparam cnt_t HEIGHT_MIN = cnt_t'(1);
  localparam cnt_t HEIGHT_MAX = cnt_t'(MAX_HEIGHT);

  localparam int TAN_SCALE = 1000;
  localparam int TAN_LO    = 414;
  localparam int TAN_HI    = 2414;
  localparam int MAG_MAX   = 255;

  localparam logic CMD_PIXEL = 1'b0;
  localparam logic CMD_FLUSH = 1'b1;

  typedef enum logic {
    REG_FRAME_WIDTH  = 1'b0,
    REG_FRAME_HEIGHT = 1'b1
  } cfg_reg_t;

  typedef enum logic [1:0] {
    DIR_0   = 2'd0,
    DIR_45  = 2'd1,
    DIR_90  = 2'd2,
    DIR_135 = 2'd3
  } dir_t;

  typedef struct packed {
    pix_t top;
    pix_t mid;
  } lb_word_t;

  typedef struct packed {
    logic             valid;
    logic             last;
    pix_t [2:0][2:0]  px;
  } kernel_t;

  typedef struct packed {
    pix_t magnitude;
    dir_t direction;
    logic last_of_frame;
  } result_t;

endpackage

`default_nettype wire

// ===== rtl/core/smd_lbuf.sv =====
// ----------------------------------------------------------------------------
// smd_lbuf
// Two-row line buffer in one memory, with write forwarding and a clearing
// sweep after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module smd_lbuf import smd_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             rd_en,
  input  logic [LB_AW-1:0] rd_addr,
  input  logic             wr_en,
  input  logic [LB_AW-1:0] wr_addr,
  input  lb_word_t         wr_data,
  output lb_word_t         rd_data,
  output logic             clearing
);

  lb_word_t         mem [MAX_WIDTH];
  lb_word_t         rd_q_r;
  lb_word_t         fwd_data_r;
  logic             fwd_r;
  logic             clearing_r;
  logic [LB_AW-1:0] clr_addr_r;

  logic             mem_we;
  logic [LB_AW-1:0] mem_wa;
  lb_word_t         mem_wd;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clearing_r <= 1'b1;
      clr_addr_r <= '0;
    end else if (clearing_r) begin
      clr_addr_r <= clr_addr_r + 1'b1;
      if (clr_addr_r == LB_AW'(MAX_WIDTH - 1)) begin
        clearing_r <= 1'b0;
      end
    end
  end

  assign mem_we = clearing_r || wr_en;
  assign mem_wa = clearing_r ? clr_addr_r : wr_addr;
  assign mem_wd = clearing_r ? '0 : wr_data;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    if (rd_en) begin
      rd_q_r <= mem[rd_addr];
    end
  end

  // same-entry read and write on one edge
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fwd_r <= 1'b0;
    end else if (rd_en) begin
      fwd_r <= wr_en && (wr_addr == rd_addr);
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      fwd_data_r <= wr_data;
    end
  end

  assign rd_data  = fwd_r ? fwd_data_r : rd_q_r;
  assign clearing = clearing_r;

endmodule

`default_nettype wire

// ===== rtl/core/smd_grad.sv =====
// ----------------------------------------------------------------------------
// smd_grad
// Three-stage Sobel gradient: kernel sums, abs values, tangent products,
// then magnitude saturation and direction decision.
// ----------------------------------------------------------------------------
`default_nettype none

module smd_grad import smd_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  kernel_t    kin,
  output logic       res_valid,
  output result_t    res,
  output logic [2:0] stage_vld
);

  localparam int SUM_W  = PIX_W + 2;
  localparam int GRAD_W = SUM_W + 1;
  localparam int MAG_W  = SUM_W + 1;
  localparam int PROD_W = SUM_W + 12;

  // stage 2: kernel
  logic            v2_r;
  logic            last2_r;
  pix_t [2:0][2:0] k_r;

  logic [SUM_W-1:0]         sx_pos, sx_neg, sy_pos, sy_neg;
  logic signed [GRAD_W-1:0] gx, gy;
  logic [SUM_W-1:0]         ax_nxt, ay_nxt;
  logic                     same_nxt;

  // stage 3: abs values
  logic             v3_r;
  logic             last3_r;
  logic             same3_r;
  logic [SUM_W-1:0] ax3_r, ay3_r;

  logic [MAG_W-1:0]  mag_nxt;
  logic [PROD_W-1:0] py_nxt, plo_nxt, phi_nxt;

  // stage 4: products
  logic              v4_r;
  logic              last4_r;
  logic              same4_r;
  logic [MAG_W-1:0]  mag4_r;
  logic [PROD_W-1:0] py4_r, plo4_r, phi4_r;

  dir_t dir;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      v2_r <= kin.valid;
      v3_r <= v2_r;
      v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    k_r     <= kin.px;
    last2_r <= kin.last;
  end

  always_comb begin
    sx_pos = SUM_W'(k_r[0][2]) + {1'b0, k_r[1][2], 1'b0} + SUM_W'(k_r[2][2]);
    sx_neg = SUM_W'(k_r[0][0]) + {1'b0, k_r[1][0], 1'b0} + SUM_W'(k_r[2][0]);
    sy_pos = SUM_W'(k_r[2][0]) + {1'b0, k_r[2][1], 1'b0} + SUM_W'(k_r[2][2]);
    sy_neg = SUM_W'(k_r[0][0]) + {1'b0, k_r[0][1], 1'b0} + SUM_W'(k_r[0][2]);
    gx = signed'({1'b0, sx_pos}) - signed'({1'b0, sx_neg});
    gy = signed'({1'b0, sy_pos}) - signed'({1'b0, sy_neg});
    ax_nxt   = gx[GRAD_W-1] ? SUM_W'(-gx) : SUM_W'(gx);
    ay_nxt   = gy[GRAD_W-1] ? SUM_W'(-gy) : SUM_W'(gy);
    same_nxt = (gx != '0) && (gy != '0) && (gx[GRAD_W-1] == gy[GRAD_W-1]);
  end

  always_ff @(posedge clk) begin
    ax3_r   <= ax_nxt;
    ay3_r   <= ay_nxt;
    same3_r <= same_nxt;
    last3_r <= last2_r;
  end

  always_comb begin
    mag_nxt = MAG_W'(ax3_r) + MAG_W'(ay3_r);
    py_nxt  = PROD_W'(ay3_r) * PROD_W'(TAN_SCALE);
    plo_nxt = PROD_W'(ax3_r) * PROD_W'(TAN_LO);
    phi_nxt = PROD_W'(ax3_r) * PROD_W'(TAN_HI);
  end

  always_ff @(posedge clk) begin
    mag4_r  <= mag_nxt;
    py4_r   <= py_nxt;
    plo4_r  <= plo_nxt;
    phi4_r  <= phi_nxt;
    same4_r <= same3_r;
    last4_r <= last3_r;
  end

  always_comb begin
    if (mag4_r == '0) begin
      dir = DIR_0;
    end else if (py4_r <= plo4_r) begin
      dir = DIR_0;
    end else if (py4_r >= phi4_r) begin
      dir = DIR_90;
    end else if (same4_r) begin
      dir = DIR_135;
    end else begin
      dir = DIR_45;
    end
  end

  assign res_valid         = v4_r;
  assign res.magnitude     = (mag4_r > MAG_W'(MAG_MAX)) ? pix_t'(MAG_MAX) : mag4_r[PIX_W-1:0];
  assign res.direction     = dir;
  assign res.last_of_frame = last4_r;
  assign stage_vld         = {v4_r, v3_r, v2_r};

endmodule

`default_nettype wire

// ===== rtl/core/smd_ofifo.sv =====
// ----------------------------------------------------------------------------
// smd_ofifo
// Small result FIFO between the gradient pipeline and the output channel.
// ----------------------------------------------------------------------------
`default_nettype none

module smd_ofifo import smd_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  result_t           din,
  input  logic              pop,
  output result_t           dout,
  output logic [OFIFO_AW:0] count
);

  result_t             mem_r [OFIFO_DEPTH];
  logic [OFIFO_AW-1:0] wptr_r, rptr_r;
  logic [OFIFO_AW:0]   cnt_r;

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wptr_r] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      if (push) begin
        wptr_r <= wptr_r + 1'b1;
      end
      if (pop) begin
        rptr_r <= rptr_r + 1'b1;
      end
      case ({push, pop})
        2'b10:   cnt_r <= cnt_r + 1'b1;
        2'b01:   cnt_r <= cnt_r - 1'b1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

  assign dout  = mem_r[rptr_r];
  assign count = cnt_r;

endmodule

`default_nettype wire

// ===== rtl/core/sobel_magnitude_direction.sv =====
// ----------------------------------------------------------------------------
// sobel_magnitude_direction
// Streaming 3x3 Sobel gradient with L1 magnitude and quantized direction.
// A result enters the output FIFO via the stage-1 and gradient registers;
//   results trail pixels by one row plus one pixel. Throughput: one word
//   per cycle while in_ready is high, one line-memory read and write per
//   word. Reset: counters clear, width and height return to 512, and the
//   line memory is swept to zero over its 1024 entries with in_ready low.
// ----------------------------------------------------------------------------
`default_nettype none

module sobel_magnitude_direction import smd_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_we,
  input  logic             cfg_index,
  input  logic [CNT_W-1:0] cfg_wdata,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic             in_cmd,
  input  logic [PIX_W-1:0] in_pixel,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [PIX_W-1:0] out_magnitude,
  output logic [1:0]       out_direction,
  output logic             out_last_of_frame
);

  localparam int FILL_W = OFIFO_AW + 2;

  cnt_t eff_w_r, eff_h_r;
  cnt_t w_clamped, h_clamped;

  cnt_t col_cnt_r, row_cnt_r;
  cnt_t col_cnt_nxt, row_cnt_nxt;

  logic in_fire;
  logic col_wrap;
  cnt_t ic, ir, row_a, orow, col_inc;
  logic prod_a, prod_b;
  logic s0_top, s0_bot, s0_last, s0_left;
  pix_t s0_pix;

  logic             s1_valid_r;
  logic [LB_AW-1:0] s1_col_r;
  pix_t             s1_pix_r;
  logic             s1_prod_r, s1_zr_r, s1_ml_r, s1_mt_r, s1_mb_r, s1_last_r;

  lb_word_t lb_rd, lb_wr;
  logic     clearing;

  pix_t [2:0][2:0] win_r;
  pix_t [2:0]      newcol;
  pix_t [2:0]      kcol2;
  kernel_t         kin;

  logic              res_valid;
  result_t           res;
  logic [2:0]        stage_vld;
  result_t           fifo_out;
  logic [OFIFO_AW:0] fifo_cnt;
  logic [2:0]        inflight;
  logic [FILL_W-1:0] fill;

  // configuration
  always_comb begin
    w_clamped = (cfg_wdata < WIDTH_MIN) ? WIDTH_MIN :
                (cfg_wdata > WIDTH_MAX) ? WIDTH_MAX : cfg_wdata;
    h_clamped = (cfg_wdata < HEIGHT_MIN) ? HEIGHT_MIN :
                (cfg_wdata > HEIGHT_MAX) ? HEIGHT_MAX : cfg_wdata;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      eff_w_r <= RESET_DIM;
      eff_h_r <= RESET_DIM;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_FRAME_WIDTH:  eff_w_r <= w_clamped;
        REG_FRAME_HEIGHT: eff_h_r <= h_clamped;
      endcase
    end
  end

  // position of the incoming word
  assign in_fire = in_valid && in_ready;

  always_comb begin
    col_wrap = col_cnt_r >= eff_w_r;
    ic       = col_wrap ? '0 : col_cnt_r;
    row_a    = col_wrap ? row_cnt_r + 1'b1 : row_cnt_r;
    ir       = (row_a > cnt_t'(eff_h_r + 1'b1)) ? '0 : row_a;
    prod_a   = (ic == '0) && (ir >= cnt_t'(2));
    prod_b   = (ic != '0) && (ir != '0) && (ir <= eff_h_r);
    orow     = prod_a ? ir - cnt_t'(2) : ir - cnt_t'(1);
    s0_top   = orow == '0;
    s0_bot   = orow == eff_h_r - cnt_t'(1);
    s0_last  = prod_a && s0_bot;
    s0_left  = prod_b && (ic == cnt_t'(1));
    s0_pix   = ((in_cmd == CMD_FLUSH) || (ir >= eff_h_r)) ? '0 : in_pixel;
    col_inc  = ic + 1'b1;
    if (s0_last) begin
      col_cnt_nxt = '0;
      row_cnt_nxt = '0;
    end else if (col_inc >= eff_w_r) begin
      col_cnt_nxt = '0;
      row_cnt_nxt = ir + 1'b1;
    end else begin
      col_cnt_nxt = col_inc;
      row_cnt_nxt = ir;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_cnt_r <= '0;
      row_cnt_r <= '0;
    end else if (in_fire) begin
      col_cnt_r <= col_cnt_nxt;
      row_cnt_r <= row_cnt_nxt;
    end
  end

  // stage 1: line memory data arrives
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= in_fire;
    end
  end

  always_ff @(posedge clk) begin
    s1_col_r  <= ic[LB_AW-1:0];
    s1_pix_r  <= s0_pix;
    s1_prod_r <= prod_a || prod_b;
    s1_zr_r   <= prod_a;
    s1_ml_r   <= s0_left;
    s1_mt_r   <= s0_top;
    s1_mb_r   <= s0_bot;
    s1_last_r <= s0_last;
  end

  assign lb_wr.top = lb_rd.mid;
  assign lb_wr.mid = s1_pix_r;

  smd_lbuf u_lbuf (
    .clk      (clk),
    .rst_n    (rst_n),
    .rd_en    (in_fire),
    .rd_addr  (ic[LB_AW-1:0]),
    .wr_en    (s1_valid_r),
    .wr_addr  (s1_col_r),
    .wr_data  (lb_wr),
    .rd_data  (lb_rd),
    .clearing (clearing)
  );

  // 3x3 window, row 0 is the oldest line
  assign newcol[0] = lb_rd.top;
  assign newcol[1] = lb_rd.mid;
  assign newcol[2] = s1_pix_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r <= '0;
    end else if (s1_valid_r) begin
      for (int r = 0; r < 3; r++) begin
        win_r[r][0] <= win_r[r][1];
        win_r[r][1] <= win_r[r][2];
        win_r[r][2] <= newcol[r];
      end
    end
  end

  // kernel with frame-edge masking
  assign kcol2 = s1_zr_r ? '0 : newcol;

  always_comb begin
    kin.valid = s1_valid_r && s1_prod_r;
    kin.last  = s1_last_r;
    for (int r = 0; r < 3; r++) begin
      kin.px[r][0] = s1_ml_r ? '0 : win_r[r][1];
      kin.px[r][1] = win_r[r][2];
      kin.px[r][2] = kcol2[r];
    end
    if (s1_mt_r) begin
      kin.px[0] = '0;
    end
    if (s1_mb_r) begin
      kin.px[2] = '0;
    end
  end

  smd_grad u_grad (
    .clk       (clk),
    .rst_n     (rst_n),
    .kin       (kin),
    .res_valid (res_valid),
    .res       (res),
    .stage_vld (stage_vld)
  );

  smd_ofifo u_ofifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (res_valid),
    .din   (res),
    .pop   (out_valid && out_ready),
    .dout  (fifo_out),
    .count (fifo_cnt)
  );

  // words in flight plus queued results never exceed the fifo depth
  always_comb begin
    inflight = 3'(s1_valid_r) + 3'(stage_vld[0]) + 3'(stage_vld[1]) + 3'(stage_vld[2]);
    fill     = FILL_W'(fifo_cnt) + FILL_W'(inflight);
  end

  assign in_ready          = !clearing && (fill < FILL_W'(OFIFO_DEPTH));
  assign out_valid         = fifo_cnt != '0;
  assign out_magnitude     = fifo_out.magnitude;
  assign out_direction     = fifo_out.direction;
  assign out_last_of_frame = fifo_out.last_of_frame;

`ifndef SYNTHESIS
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill <= FILL_W'(OFIFO_DEPTH))
    else $error("result fifo overcommitted");

  a_frame_restart: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && s0_last) |=> (col_cnt_r == '0 && row_cnt_r == '0))
    else $error("counters not cleared after last result");

  a_no_work_in_sweep: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r |-> !clearing)
    else $error("line memory access during clearing sweep");
`endif

endmodule

`default_nettype wire
